// File: sv/ilda_pkg.sv
// ----------------------------------------------------------------------------
// ilda_pkg: shared types and tables of the ILDA stream parser
// Result kinds, error codes, register indexes and default color tables.
// ----------------------------------------------------------------------------
`default_nettype none
package ilda_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int HEADER_BYTES  = 32;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_FW        = PAL_AW + 1;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_HEADER  = 2'd1,
    ERR_FORMAT  = 2'd2,
    ERR_PARTIAL = 2'd3
  } err_e;

  localparam logic CFG_SHORT_TABLE  = 1'b0;
  localparam logic CFG_FILE_PALETTE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               blanked;
    logic               img_last;
    logic [15:0]        frame_points;
    logic [1:0]         error_code;
    logic [15:0]        frames_seen;
  } out_item_t;

  typedef struct packed {
    logic       index;
    logic [0:0] data;
  } cfg_item_t;

  function automatic logic [3:0] rec_len(input logic [2:0] fmt);
    case (fmt)
      3'd0:    rec_len = 4'd8;
      3'd1:    rec_len = 4'd6;
      3'd4:    rec_len = 4'd10;
      3'd5:    rec_len = 4'd8;
      default: rec_len = 4'd3;
    endcase
  endfunction

  localparam logic [23:0] SHORT_TAB [64] = '{
    24'hFF0000,24'hFF1000,24'hFF2000,24'hFF3000,24'hFF4000,24'hFF5000,24'hFF6000,24'hFF7000,
    24'hFF8000,24'hFF9000,24'hFFA000,24'hFFB000,24'hFFC000,24'hFFD000,24'hFFE000,24'hFFF000,
    24'hFFFF00,24'hE0FF00,24'hC0FF00,24'hA0FF00,24'h80FF00,24'h60FF00,24'h40FF00,24'h20FF00,
    24'h00FF00,24'h00FF24,24'h00FF49,24'h00FF6D,24'h00FF92,24'h00FFB6,24'h00FFDB,24'h00FFFF,
    24'h00E3FF,24'h00C6FF,24'h00AAFF,24'h008EFF,24'h0071FF,24'h0055FF,24'h0038FF,24'h001CFF,
    24'h0000FF,24'h2000FF,24'h4000FF,24'h6000FF,24'h8000FF,24'hA000FF,24'hC000FF,24'hE000FF,
    24'hFF00FF,24'hFF20FF,24'hFF40FF,24'hFF60FF,24'hFF80FF,24'hFFA0FF,24'hFFC0FF,24'hFFE0FF,
    24'hFFFFFF,24'hFFE0E0,24'hFFC0C0,24'hFFA0A0,24'hFF8080,24'hFF6060,24'hFF4040,24'hFF2020
  };

  localparam logic [23:0] LONG_TAB [256] = '{
    24'h000000,24'hFFFFFF,24'hFF0000,24'hFFFF00,24'h00FF00,24'h00FFFF,24'h0000FF,24'hFF00FF,
    24'hFF8080,24'hFF8C80,24'hFF9780,24'hFFA380,24'hFFAE80,24'hFFBA80,24'hFFC580,24'hFFD180,
    24'hFFDC80,24'hFFE880,24'hFFF380,24'hFFFF80,24'hF3FF80,24'hE8FF80,24'hDCFF80,24'hD1FF80,
    24'hC5FF80,24'hBAFF80,24'hAEFF80,24'hA3FF80,24'h97FF80,24'h8CFF80,24'h80FF80,24'h80FF8C,
    24'h80FF97,24'h80FFA3,24'h80FFAE,24'h80FFBA,24'h80FFC5,24'h80FFD1,24'h80FFDC,24'h80FFE8,
    24'h80FFF3,24'h80FFFF,24'h80F3FF,24'h80E8FF,24'h80DCFF,24'h80D1FF,24'h80C5FF,24'h80BAFF,
    24'h80AEFF,24'h80A3FF,24'h8097FF,24'h808CFF,24'h8080FF,24'h8C80FF,24'h9780FF,24'hA380FF,
    24'hAE80FF,24'hBA80FF,24'hC580FF,24'hD180FF,24'hDC80FF,24'hE880FF,24'hF380FF,24'hFF80FF,
    24'hFF80F3,24'hFF80E8,24'hFF80DC,24'hFF80D1,24'hFF80C5,24'hFF80BA,24'hFF80AE,24'hFF80A3,
    24'hFF8097,24'hFF808C,24'hFF0000,24'hFF1700,24'hFF2E00,24'hFF4600,24'hFF5D00,24'hFF7400,
    24'hFF8B00,24'hFFA200,24'hFFB900,24'hFFD100,24'hFFE800,24'hFFFF00,24'hE8FF00,24'hD1FF00,
    24'hB9FF00,24'hA2FF00,24'h8BFF00,24'h74FF00,24'h5DFF00,24'h46FF00,24'h2EFF00,24'h17FF00,
    24'h00FF00,24'h00FF17,24'h00FF2E,24'h00FF46,24'h00FF5D,24'h00FF74,24'h00FF8B,24'h00FFA2,
    24'h00FFB9,24'h00FFD1,24'h00FFE8,24'h00FFFF,24'h00E8FF,24'h00D1FF,24'h00B9FF,24'h00A2FF,
    24'h008BFF,24'h0074FF,24'h005DFF,24'h0046FF,24'h002EFF,24'h0017FF,24'h0000FF,24'h1700FF,
    24'h2E00FF,24'h4600FF,24'h5D00FF,24'h7400FF,24'h8B00FF,24'hA200FF,24'hB900FF,24'hD100FF,
    24'hE800FF,24'hFF00FF,24'hFF00E8,24'hFF00D1,24'hFF00B9,24'hFF00A2,24'hFF008B,24'hFF0074,
    24'hFF005D,24'hFF0046,24'hFF002E,24'hFF0017,24'h800000,24'h800C00,24'h801700,24'h802300,
    24'h802F00,24'h803A00,24'h804600,24'h805100,24'h805D00,24'h806900,24'h807400,24'h808000,
    24'h748000,24'h698000,24'h5D8000,24'h518000,24'h468000,24'h3A8000,24'h2F8000,24'h238000,
    24'h178000,24'h0C8000,24'h008000,24'h00800C,24'h008017,24'h008023,24'h00802F,24'h00803A,
    24'h008046,24'h008051,24'h00805D,24'h008069,24'h008074,24'h008080,24'h007480,24'h006980,
    24'h005D80,24'h005180,24'h004680,24'h003A80,24'h002F80,24'h002380,24'h001780,24'h000C80,
    24'h000080,24'h0C0080,24'h170080,24'h230080,24'h2F0080,24'h3A0080,24'h460080,24'h510080,
    24'h5D0080,24'h690080,24'h740080,24'h800080,24'h800074,24'h800069,24'h80005D,24'h800051,
    24'h800046,24'h80003A,24'h80002F,24'h800023,24'h800017,24'h80000C,24'hFFC0C0,24'hFF4040,
    24'hC00000,24'h400000,24'hFFFFC0,24'hFFFF40,24'hC0C000,24'h404000,24'hC0FFC0,24'h40FF40,
    24'h00C000,24'h004000,24'hC0FFFF,24'h40FFFF,24'h00C0C0,24'h004040,24'hC0C0FF,24'h4040FF,
    24'h0000C0,24'h000040,24'hFFC0FF,24'hFF40FF,24'hC000C0,24'h400040,24'hFF6060,24'hFFFFFF,
    24'hF5F5F5,24'hEBEBEB,24'hE0E0E0,24'hD5D5D5,24'hCBCBCB,24'hC0C0C0,24'hB5B5B5,24'hABABAB,
    24'hA0A0A0,24'h959595,24'h8B8B8B,24'h808080,24'h757575,24'h6B6B6B,24'h606060,24'h555555,
    24'h4B4B4B,24'h404040,24'h353535,24'h2B2B2B,24'h202020,24'h151515,24'h0B0B0B,24'h000000
  };

endpackage
`default_nettype wire

// File: sv/ilda_stream_if.sv
// ----------------------------------------------------------------------------
// ilda_stream_if: valid/ready channel
// Carries one payload of a given type from a source to a sink.
// ----------------------------------------------------------------------------
`default_nettype none
interface ilda_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/ilda_ram.sv
// ----------------------------------------------------------------------------
// ilda_ram: generic single-port-write, one-read RAM
// Registered read data, no reset of the contents.
// ----------------------------------------------------------------------------
`default_nettype none
module ilda_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// File: sv/ilda_stream_parser.sv
// ----------------------------------------------------------------------------
// ilda_stream_parser: ILDA byte stream parser
// Checks headers, announces frames, decodes point records and palettes.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, unless the pipe stalls. Each
// byte updates the position counter and record buffer in the accept cycle;
// a record's last byte starts a one-stage result pipe (palette RAM read,
// default table lookup) whose register feeds the output register, and a
// byte is accepted every cycle while the output is taken. The palette store
// is a 256-entry RAM with no clearing; only entries below the fill count
// are ever used.
`default_nettype none
module ilda_stream_parser (
  input wire logic clk_i,
  input wire logic rst_ni,
  ilda_stream_if.sink   in_if,
  ilda_stream_if.source out_if,
  ilda_stream_if.sink   cfg_if
);
  import ilda_pkg::*;

  // configuration
  logic short_q, filepal_q;
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q   <= 1'b0;
      filepal_q <= 1'b0;
    end else if (cfg_if.valid) begin
      if (cfg_if.payload.index == CFG_SHORT_TABLE)  short_q   <= cfg_if.payload.data[0];
      if (cfg_if.payload.index == CFG_FILE_PALETTE) filepal_q <= cfg_if.payload.data[0];
    end
  end

  // pipeline: stage 1 (s1) holds raw result, output register (o)
  logic      s1_v_q, o_v_q;
  out_item_t s1_q, o_q;
  logic      s1_idx_q;     // stage 1 needs an indexed color
  logic      s1_pal_q;     // look up file palette
  logic      s1_hit_q;     // index inside range
  logic [7:0] s1_ci_q;
  logic      stall;
  assign stall = o_v_q && !out_if.ready && s1_v_q;
  assign in_if.ready = !stall;

  logic acc;
  assign acc = in_if.valid && in_if.ready;

  // parser state
  logic              inrec_q;
  logic [5:0]        pos_q;
  logic [7:0]        rb_q [10];
  logic [2:0]        fmt_q;
  logic [15:0]       ann_q, done_q, frames_q;
  logic [PAL_FW-1:0] fill_q;
  logic              err_q;

  logic [7:0] b;
  logic       eos;
  assign b   = in_if.payload.data_byte;
  assign eos = in_if.payload.end_of_stream;

  // current record bytes, with this byte merged
  logic [7:0] d [10];
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      d[k] = rb_q[k];
      if (pos_q[3:0] == 4'(k) && pos_q[5:4] == 2'b00) d[k] = b;
    end
  end

  // header fields, all captured before the last header byte
  logic [7:0] hfmt, hc_hi, hc_lo;
  assign hfmt  = rb_q[4];
  assign hc_hi = rb_q[5];
  assign hc_lo = rb_q[6];

  logic        hdr_end, rec_end, sig_ok;
  logic [15:0] hcount, done_n;
  logic [3:0]  rlen;
  assign rlen    = rec_len(fmt_q);
  assign hdr_end = !inrec_q && (pos_q == 6'(HEADER_BYTES - 1));
  assign rec_end = inrec_q && ({2'b00, pos_q} + 8'd1 >= {4'd0, rlen});
  assign sig_ok  = rb_q[0] == "I" && rb_q[1] == "L" && rb_q[2] == "D" && rb_q[3] == "A";
  assign hcount  = {hc_hi, hc_lo};
  assign done_n  = done_q + 16'd1;

  logic        pt_fmt, three_d, pal_wr;
  logic [7:0]  st, ci;
  assign pt_fmt  = fmt_q == 3'd0 || fmt_q == 3'd1 || fmt_q == 3'd4 || fmt_q == 3'd5;
  assign three_d = fmt_q == 3'd0 || fmt_q == 3'd4;
  assign st      = three_d ? d[6] : d[4];
  assign ci      = three_d ? d[7] : d[5];
  assign pal_wr  = acc && !err_q && !eos && rec_end && fmt_q == 3'd2
                   && fill_q < PAL_FW'(PALETTE_DEPTH);

  // result produced by this byte
  logic      res_v;
  out_item_t res;
  logic      r_idx, r_pal, r_hit;
  always_comb begin
    res_v = 1'b0;
    res   = '0;
    r_idx = 1'b0;
    r_pal = filepal_q;
    r_hit = 1'b0;
    res.frames_seen = frames_q;
    if (!err_q) begin
      if (eos) begin
        res_v = 1'b1;
        if (pos_q != 6'd0) begin
          res.kind = KIND_ERROR;
          res.error_code = ERR_PARTIAL;
        end else begin
          res.kind = KIND_END;
        end
      end else if (hdr_end) begin
        if (!sig_ok) begin
          res_v = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_HEADER;
        end else if (hfmt >= 8'd6) begin
          res_v = 1'b1;
          res.kind = KIND_ERROR;
          res.error_code = ERR_FORMAT;
        end else if (hcount != 16'd0 && hfmt != 8'd2 && hfmt != 8'd3) begin
          res_v = 1'b1;
          res.kind = KIND_FRAME;
          res.frame_points = hcount;
          res.frames_seen = frames_q + 16'd1;
        end
      end else if (rec_end && pt_fmt) begin
        res_v = 1'b1;
        res.kind = KIND_POINT;
        res.coord_x = {d[0], d[1]};
        res.coord_y = {d[2], d[3]};
        res.coord_z = three_d ? {d[4], d[5]} : 16'sd0;
        res.blanked = st[6];
        res.img_last = st[7];
        if (fmt_q[2]) begin
          res.blue  = st[6] ? 8'd0 : ci;
          res.green = st[6] ? 8'd0 : (three_d ? d[8] : d[6]);
          res.red   = st[6] ? 8'd0 : (three_d ? d[9] : d[7]);
        end else begin
          r_idx = !st[6];
          r_hit = filepal_q ? ({1'b0, ci} < fill_q) : (short_q ? ci < 8'd64 : 1'b1);
        end
      end
    end
  end

  // parser state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inrec_q  <= 1'b0;
      pos_q    <= '0;
      fmt_q    <= '0;
      ann_q    <= '0;
      done_q   <= '0;
      frames_q <= '0;
      fill_q   <= '0;
      err_q    <= 1'b0;
    end else if (acc && !err_q) begin
      if (eos) begin
        pos_q <= '0;
        if (pos_q != 6'd0) err_q <= 1'b1;
        else begin
          inrec_q <= 1'b0;
          done_q  <= '0;
        end
      end else if (!inrec_q) begin
        pos_q <= hdr_end ? 6'd0 : pos_q + 6'd1;
        if (hdr_end) begin
          if (!sig_ok || hfmt >= 8'd6) err_q <= 1'b1;
          else begin
            fmt_q  <= hfmt[2:0];
            ann_q  <= hcount;
            done_q <= '0;
            if (hcount != 16'd0) begin
              inrec_q <= 1'b1;
              if (hfmt == 8'd2) fill_q <= '0;
              if (hfmt != 8'd2 && hfmt != 8'd3) frames_q <= frames_q + 16'd1;
            end
          end
        end
      end else begin
        pos_q <= rec_end ? 6'd0 : pos_q + 6'd1;
        if (rec_end) begin
          done_q <= done_n;
          if (done_n >= ann_q) inrec_q <= 1'b0;
          if (pal_wr) fill_q <= fill_q + PAL_FW'(1);
        end
      end
    end
  end

  // record buffer: header keeps signature, format and count bytes
  always_ff @(posedge clk_i) begin
    if (acc && !err_q && !eos) begin
      if (!inrec_q) begin
        if (pos_q < 6'd4) rb_q[pos_q[3:0]] <= b;
        else if (pos_q == 6'd7) rb_q[4] <= b;
        else if (pos_q == 6'd24) rb_q[5] <= b;
        else if (pos_q == 6'd25) rb_q[6] <= b;
      end else if (pos_q < 6'd10) begin
        rb_q[pos_q[3:0]] <= b;
      end
    end
  end

  // palette store
  logic [23:0] pal_rd;
  ilda_ram #(.Width(24), .Depth(PALETTE_DEPTH)) u_pal (
    .clk_i   (clk_i),
    .we_i    (pal_wr),
    .waddr_i (fill_q[PAL_AW-1:0]),
    .wdata_i ({d[0], d[1], d[2]}),
    .re_i    (!stall),
    .raddr_i (ci[PAL_AW-1:0]),
    .rdata_o (pal_rd)
  );

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (!stall) s1_v_q <= acc && res_v;
  end
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      s1_q     <= res;
      s1_idx_q <= r_idx;
      s1_pal_q <= r_pal;
      s1_hit_q <= r_hit;
      s1_ci_q  <= ci;
    end
  end

  // resolve indexed color
  logic [23:0] rgb;
  out_item_t   s1_fin;
  always_comb begin
    rgb = 24'd0;
    if (s1_hit_q) begin
      if (s1_pal_q) rgb = pal_rd;
      else if (short_q) rgb = SHORT_TAB[s1_ci_q[5:0]];
      else rgb = LONG_TAB[s1_ci_q];
    end
    s1_fin = s1_q;
    if (s1_idx_q) begin
      s1_fin.red   = rgb[23:16];
      s1_fin.green = rgb[15:8];
      s1_fin.blue  = rgb[7:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (!o_v_q || out_if.ready) o_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (!o_v_q || out_if.ready) o_q <= s1_fin;
  end
  assign out_if.valid   = o_v_q;
  assign out_if.payload = o_q;

  // checks
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.payload))
    else $error("result changed under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> o_v_q && s1_v_q)
    else $error("input blocked without full pipe");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(err_q) |-> err_q)
    else $error("sticky error cleared");
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inrec_q |-> pos_q < 6'd10)
    else $error("record position out of range");
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: ILDA stream parser check
// Drives headers, point, palette and skipped records byte by byte with random
// gaps and back-pressure, predicts each frame, point, end and error result
// and compares every field of what the parser returns.
// ----------------------------------------------------------------------------
module testbench;
  import ilda_pkg::*;

  localparam int LIMIT     = 1000000;
  localparam int HOLD_LONG = 300;
  localparam int OP_HDR    = 0;
  localparam int OP_REC    = 1;
  localparam int OP_EOS    = 2;
  localparam int EXP_ANY   = -1;
  localparam int EXP_NONE  = -2;

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   errors;
  int   sent;
  bit   no_idle;
  bit   hold_req;

  ilda_stream_if #(.payload_t(in_item_t))  in_if ();
  ilda_stream_if #(.payload_t(out_item_t)) out_if ();
  ilda_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  ilda_stream_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Clock and run limit
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Parser mirror: configuration and state
  logic        sh_tab, file_pal;
  logic        in_rec, err_l;
  int          bidx;
  logic [7:0]  rbuf [10];
  logic [2:0]  rfmt;
  logic [15:0] announced, done_cnt, frame_cnt;
  logic [23:0] pal_mem [256];
  int          pal_fill;
  out_item_t   expected_q [$];
  out_item_t   last_pushed;
  int          pushes;

  function automatic int rec_bytes(input logic [2:0] fmt);
    case (fmt)
      3'd0, 3'd5: return 8;
      3'd1:       return 6;
      3'd4:       return 10;
      default:    return 3;
    endcase
  endfunction

  function automatic logic [23:0] index_color(input logic [7:0] idx);
    if (file_pal) return (idx < pal_fill) ? pal_mem[idx] : 24'h0;
    if (sh_tab) return (idx < 64) ? SHORT_TAB[idx[5:0]] : 24'h0;
    return LONG_TAB[idx];
  endfunction

  task automatic push_result(input out_item_t r);
    expected_q.push_back(r);
    last_pushed = r;
    pushes++;
  endtask

  task automatic raise_err(input err_e code);
    out_item_t r;
    r = '0;
    err_l = 1'b1;
    r.kind = KIND_ERROR;
    r.error_code = code;
    r.frames_seen = frame_cnt;
    push_result(r);
  endtask

  task automatic close_header();
    out_item_t r;
    logic [15:0] cnt;
    r = '0;
    if (rbuf[0] != "I" || rbuf[1] != "L" || rbuf[2] != "D" || rbuf[3] != "A") begin
      raise_err(ERR_HEADER);
      return;
    end
    if (rbuf[4] >= 6) begin
      raise_err(ERR_FORMAT);
      return;
    end
    cnt = {rbuf[5], rbuf[6]};
    rfmt = rbuf[4][2:0];
    announced = cnt;
    done_cnt = '0;
    if (cnt == 0) return;
    if (rfmt == 3'd2) pal_fill = 0;
    in_rec = 1'b1;
    if (rfmt == 3'd2 || rfmt == 3'd3) return;
    frame_cnt++;
    r.kind = KIND_FRAME;
    r.frame_points = cnt;
    r.frames_seen = frame_cnt;
    push_result(r);
  endtask

  task automatic close_record();
    out_item_t r;
    int st;
    logic [23:0] rgb;
    logic [7:0] stat;
    bit three_d;
    r = '0;
    if (rfmt inside {3'd0, 3'd1, 3'd4, 3'd5}) begin
      three_d = (rfmt == 3'd0 || rfmt == 3'd4);
      st = three_d ? 6 : 4;
      stat = rbuf[st];
      if (rfmt <= 1) rgb = index_color(rbuf[st + 1]);
      else rgb = {rbuf[st + 3], rbuf[st + 2], rbuf[st + 1]};
      if (stat[6]) rgb = '0;
      r.kind = KIND_POINT;
      r.coord_x = {rbuf[0], rbuf[1]};
      r.coord_y = {rbuf[2], rbuf[3]};
      r.coord_z = three_d ? {rbuf[4], rbuf[5]} : 16'h0;
      {r.red, r.green, r.blue} = rgb;
      r.blanked = stat[6];
      r.img_last = stat[7];
      r.frames_seen = frame_cnt;
      push_result(r);
    end else if (rfmt == 3'd2 && pal_fill < PALETTE_DEPTH) begin
      pal_mem[pal_fill] = {rbuf[0], rbuf[1], rbuf[2]};
      pal_fill++;
    end
    done_cnt++;
    if (done_cnt >= announced) in_rec = 1'b0;
  endtask

  // Advance the mirror by one accepted byte request
  task automatic predict_byte(input logic [7:0] b, input logic eos);
    out_item_t r;
    r = '0;
    if (err_l) return;
    if (eos) begin
      if (bidx != 0) begin
        bidx = 0;
        raise_err(ERR_PARTIAL);
      end else begin
        in_rec = 1'b0;
        done_cnt = '0;
        r.kind = KIND_END;
        r.frames_seen = frame_cnt;
        push_result(r);
      end
    end else if (!in_rec) begin
      if (bidx < 4) rbuf[bidx] = b;
      else if (bidx == 7) rbuf[4] = b;
      else if (bidx == 24) rbuf[5] = b;
      else if (bidx == 25) rbuf[6] = b;
      if (bidx + 1 < HEADER_BYTES) bidx++;
      else begin
        bidx = 0;
        close_header();
      end
    end else begin
      if (bidx < 10) rbuf[bidx] = b;
      if (bidx + 1 < rec_bytes(rfmt)) bidx++;
      else begin
        bidx = 0;
        close_record();
      end
    end
  endtask

  // Sender: enter and leave at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b, eos);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_SHORT_TABLE) sh_tab = val;
    else file_pal = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Header with random filler; bad selects a broken signature
  task automatic send_header(input logic [7:0] fmt, input logic [15:0] cnt, input bit bad);
    logic [7:0] b;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = 8'($urandom_range(0, 255));
      case (i)
        0: b = bad ? 8'h58 : "I";
        1: b = "L";
        2: b = "D";
        3: b = "A";
        7: b = fmt;
        24: b = cnt[15:8];
        25: b = cnt[7:0];
        default: ;
      endcase
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_record(input logic [2:0] fmt, input logic [7:0] stat,
                             input logic [23:0] col, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
    logic [7:0] rec [10];
    int n;
    n = rec_bytes(fmt);
    rec[0] = x[15:8]; rec[1] = x[7:0]; rec[2] = y[15:8]; rec[3] = y[7:0];
    case (fmt)
      3'd0: begin
        rec[4] = z[15:8]; rec[5] = z[7:0]; rec[6] = stat; rec[7] = col[7:0];
      end
      3'd1: begin
        rec[4] = stat; rec[5] = col[7:0];
      end
      3'd4: begin
        rec[4] = z[15:8]; rec[5] = z[7:0]; rec[6] = stat;
        rec[7] = col[7:0]; rec[8] = col[15:8]; rec[9] = col[23:16];
      end
      3'd5: begin
        rec[4] = stat; rec[5] = col[7:0]; rec[6] = col[15:8]; rec[7] = col[23:16];
      end
      default: begin
        rec[0] = col[23:16]; rec[1] = col[15:8]; rec[2] = col[7:0];
      end
    endcase
    for (int i = 0; i < n; i++) send_byte(rec[i], 1'b0);
  endtask

  task automatic send_rand_record(input logic [2:0] fmt);
    send_record(fmt, 8'($urandom_range(0, 255)), 24'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()));
  endtask

  // Receiver: compare each result with the oldest expectation
  task automatic cmp(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
      errors++;
    end
  endtask

  initial begin
    int gap;
    out_item_t e, a;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_LONG) @(negedge clk_i);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      a = out_if.payload;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, a);
        errors++;
      end else begin
        e = expected_q.pop_front();
        cmp("kind", e.kind, a.kind);
        cmp("coord_x", e.coord_x, a.coord_x);
        cmp("coord_y", e.coord_y, a.coord_y);
        cmp("coord_z", e.coord_z, a.coord_z);
        cmp("red", e.red, a.red);
        cmp("green", e.green, a.green);
        cmp("blue", e.blue, a.blue);
        cmp("blanked", e.blanked, a.blanked);
        cmp("img_last", e.img_last, a.img_last);
        cmp("frame_points", e.frame_points, a.frame_points);
        cmp("error_code", e.error_code, a.error_code);
        cmp("frames_seen", e.frames_seen, a.frames_seen);
      end
    end
  end

  // Directed table: op, format, count, status, color, x, short, palette, expect
  typedef struct {
    int          op;
    int          fmt;
    int          cnt;
    logic [7:0]  stat;
    logic [23:0] col;
    logic [15:0] x;
    int          sh;
    int          fp;
    int          want;
  } row_t;

  localparam int NROWS = 23;
  row_t rows [NROWS] = '{
    '{OP_EOS, 0, 0, 8'h00, 24'h000000, 16'h0000, -1, -1, KIND_END},
    '{OP_HDR, 0, 2, 8'h00, 24'h000000, 16'h0000, -1, -1, KIND_FRAME},
    '{OP_REC, 0, 0, 8'h00, 24'h000000, 16'h8000, -1, -1, EXP_ANY},
    '{OP_REC, 0, 0, 8'hC0, 24'h0000FF, 16'h7FFF, -1, -1, EXP_ANY},
    '{OP_HDR, 2, 3, 8'h00, 24'h000000, 16'h0000, -1, -1, EXP_NONE},
    '{OP_REC, 2, 0, 8'h00, 24'hFF0000, 16'h0000, -1, -1, EXP_NONE},
    '{OP_REC, 2, 0, 8'h00, 24'h00FF00, 16'h0000, -1, -1, EXP_NONE},
    '{OP_REC, 2, 0, 8'h00, 24'hFFFFFF, 16'h0000, -1, -1, EXP_NONE},
    '{OP_HDR, 1, 2, 8'h00, 24'h000000, 16'h0000, -1, 1, KIND_FRAME},
    '{OP_REC, 1, 0, 8'h3F, 24'h000002, 16'hFFFF, -1, -1, EXP_ANY},
    '{OP_REC, 1, 0, 8'h80, 24'h000003, 16'h0001, -1, -1, EXP_ANY},
    '{OP_HDR, 3, 1, 8'h00, 24'h000000, 16'h0000, -1, -1, EXP_NONE},
    '{OP_REC, 3, 0, 8'h00, 24'hA5A5A5, 16'h0000, -1, -1, EXP_NONE},
    '{OP_HDR, 0, 0, 8'h00, 24'h000000, 16'h0000, -1, -1, EXP_NONE},
    '{OP_HDR, 4, 1, 8'h00, 24'h000000, 16'h0000, 1, 0, KIND_FRAME},
    '{OP_REC, 4, 0, 8'h00, 24'hFF00FF, 16'h1234, -1, -1, EXP_ANY},
    '{OP_HDR, 5, 2, 8'h00, 24'h000000, 16'h0000, -1, -1, KIND_FRAME},
    '{OP_REC, 5, 0, 8'h00, 24'h123456, 16'h8000, -1, -1, EXP_ANY},
    '{OP_REC, 5, 0, 8'h40, 24'hFFFFFF, 16'h7FFF, -1, -1, EXP_ANY},
    '{OP_HDR, 1, 2, 8'h00, 24'h000000, 16'h0000, -1, -1, KIND_FRAME},
    '{OP_REC, 1, 0, 8'h00, 24'h00003F, 16'h5555, -1, -1, EXP_ANY},
    '{OP_REC, 1, 0, 8'h80, 24'h000040, 16'hAAAA, -1, -1, EXP_ANY},
    '{OP_EOS, 0, 0, 8'h00, 24'h000000, 16'h0000, 0, -1, KIND_END}
  };

  // Stimulus
  initial begin
    int p0, cnt, fmt, code;
    cycles = 0;
    errors = 0;
    sent = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    pushes = 0;
    sh_tab = 1'b0; file_pal = 1'b0; in_rec = 1'b0; err_l = 1'b0; bidx = 0;
    rfmt = '0; announced = '0; done_cnt = '0; frame_cnt = '0; pal_fill = 0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int i = 0; i < NROWS; i++) begin
      if (rows[i].sh >= 0) write_reg(CFG_SHORT_TABLE, rows[i].sh[0]);
      if (rows[i].fp >= 0) write_reg(CFG_FILE_PALETTE, rows[i].fp[0]);
      p0 = pushes;
      case (rows[i].op)
        OP_HDR: send_header(8'(rows[i].fmt), 16'(rows[i].cnt), 1'b0);
        OP_REC: send_record(3'(rows[i].fmt), rows[i].stat, rows[i].col, rows[i].x,
                            ~rows[i].x, rows[i].x ^ 16'h8000);
        default: send_byte(8'($urandom_range(0, 255)), 1'b1);
      endcase
      if (rows[i].want == EXP_NONE && pushes != p0) begin
        $display("%0t: row %0d expected none, actual %0d results", $realtime, i,
                 pushes - p0);
        errors++;
      end else if (rows[i].want >= 0 &&
                   (pushes == p0 || last_pushed.kind != rows[i].want)) begin
        $display("%0t: row %0d kind expected %0d, actual %0d", $realtime, i,
                 rows[i].want, last_pushed.kind);
        errors++;
      end
    end

    // Hold the receiver off while a point frame streams in at full rate
    no_idle = 1'b1;
    hold_req = 1'b1;
    send_header(8'd0, 16'd4, 1'b0);
    for (int k = 0; k < 4; k++) send_rand_record(3'd0);

    // Random frames, palettes and skipped records
    while (sent < 440) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        write_reg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 40) == 0) drain();
      case ($urandom_range(0, 9))
        0, 1: fmt = 2;
        2:    fmt = 3;
        default: fmt = $urandom_range(0, 5);
      endcase
      if ($urandom_range(0, 9) == 0) cnt = 0;
      else cnt = $urandom_range(1, 4);
      send_header(8'(fmt), 16'(cnt), 1'b0);
      for (int k = 0; k < cnt; k++) send_rand_record(3'(fmt));
      if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
    end

    // One sticky error, then traffic that must stay silent
    no_idle = 1'b0;
    code = $urandom_range(1, 3);
    case (code)
      1: send_header(8'd0, 16'd1, 1'b1);
      2: send_header(8'($urandom_range(6, 255)), 16'd1, 1'b0);
      default: begin
        send_header(8'd0, 16'd2, 1'b0);
        send_rand_record(3'd0);
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'h00, 1'b1);
      end
    endcase
    send_header(8'd1, 16'd1, 1'b0);
    send_rand_record(3'd1);
    send_byte(8'h00, 1'b1);

    drain();
    repeat (20) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $realtime,
               expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ilda_pkg.sv
sv/ilda_stream_if.sv
sv/ilda_ram.sv
sv/ilda_stream_parser.sv
tb/sv/testbench.sv
